// File: rtl/dcreg_pkg.sv
// Shared types, constants and register codes of the depth-to-color registration core.
`timescale 1ns / 1ps

package dcreg_pkg;

   // Depth frame size used for the inside test.
   localparam int unsigned DEPTH_COLS = 640;
   localparam int unsigned DEPTH_ROWS = 480;

   // Back-projection divider: dividend and divisor widths.
   localparam int unsigned BP_NW = 39;
   localparam int unsigned BP_DW = 17;

   // Projection divider: dividend and divisor widths.
   localparam int unsigned PJ_NW = 50;
   localparam int unsigned PJ_DW = 36;

   typedef enum logic [2:0] {
      REG_DEPTH_FOCAL  = 3'd0,
      REG_DEPTH_CENTER = 3'd1,
      REG_COLOR_FOCAL  = 3'd2,
      REG_COLOR_CENTER = 3'd3,
      REG_EXT_ROW_X    = 3'd4,
      REG_EXT_ROW_Y    = 3'd5,
      REG_EXT_ROW_Z    = 3'd6,
      REG_FRAME_SIZE   = 3'd7
   } csr_index_type;

   localparam logic [31:0] RST_DEPTH_FOCAL  = 32'h2440_2440;
   localparam logic [31:0] RST_DEPTH_CENTER = 32'h1400_0F00;
   localparam logic [31:0] RST_COLOR_FOCAL  = 32'h4199_E260;
   localparam logic [31:0] RST_COLOR_CENTER = 32'h2800_2000;
   localparam logic [63:0] RST_EXT_ROW_X    = 64'h4000_0000_0000_0000;
   localparam logic [63:0] RST_EXT_ROW_Y    = 64'h0000_4000_0000_0000;
   localparam logic [63:0] RST_EXT_ROW_Z    = 64'h0000_0000_4000_0000;
   localparam logic [31:0] RST_FRAME_SIZE   = 32'h0500_0400;

   typedef struct packed {
      logic [9:0]  depth_col;
      logic [9:0]  depth_row;
      logic [15:0] depth_mm;
   } req_type;

   typedef struct packed {
      logic signed [15:0] color_col;
      logic signed [15:0] color_row;
      logic               inside_frame;
   } rsp_type;

   // Decoded configuration. rot[i][2-j] is row i, column j in signed Q2.14.
   typedef struct packed {
      logic [15:0]            dfx;
      logic [15:0]            dfy;
      logic [15:0]            dcx;
      logic [15:0]            dcy;
      logic [15:0]            cfx;
      logic [15:0]            cfy;
      logic [15:0]            ccx;
      logic [15:0]            ccy;
      logic [2:0][2:0][15:0]  rot;
      logic [2:0][15:0]       trans;
      logic [15:0]            fw;
      logic [15:0]            fh;
   } cfg_type;

   // Point in the depth camera frame, Q.4 millimetres.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [19:0]        z;
      logic               inrange;
   } point_type;

   // Point in the color camera frame, Q.4 millimetres.
   typedef struct packed {
      logic signed [31:0] xc;
      logic signed [31:0] yc;
      logic signed [31:0] zc;
      logic               inrange;
   } cam_type;

endpackage

// File: rtl/dcreg_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module dcreg_div #(
   parameter int unsigned NW = 39,
   parameter int unsigned DW = 17,
   parameter int unsigned TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag,
   output logic          out_valid,
   output logic [NW-1:0] quo,
   output logic [TW-1:0] out_tag
);

   logic          valid_ff [NW];
   logic [DW-1:0] rem_ff   [NW];
   logic [NW-1:0] num_ff   [NW];
   logic [NW-1:0] quo_ff   [NW];
   logic [DW-1:0] den_ff   [NW];
   logic [TW-1:0] tag_ff   [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          v_i;
      logic [DW-1:0] r_i;
      logic [NW-1:0] n_i;
      logic [NW-1:0] q_i;
      logic [DW-1:0] d_i;
      logic [TW-1:0] t_i;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;

      if (k == 0) begin : g_first
         assign v_i = in_valid;
         assign r_i = '0;
         assign n_i = num;
         assign q_i = '0;
         assign d_i = den;
         assign t_i = tag;
      end else begin : g_next
         assign v_i = valid_ff[k-1];
         assign r_i = rem_ff[k-1];
         assign n_i = num_ff[k-1];
         assign q_i = quo_ff[k-1];
         assign d_i = den_ff[k-1];
         assign t_i = tag_ff[k-1];
      end

      assign trial  = {r_i, n_i[NW-1]};
      assign ge     = trial >= {1'b0, d_i};
      assign rem_in = ge ? DW'(trial - {1'b0, d_i}) : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= {n_i[NW-2:0], 1'b0};
            quo_ff[k] <= {q_i[NW-2:0], ge};
            den_ff[k] <= d_i;
            tag_ff[k] <= t_i;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign quo       = quo_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule

// File: rtl/dcreg_backproj.sv
// Back-projection of a depth pixel into a Q.4 millimetre point of the depth camera.
`timescale 1ns / 1ps

module dcreg_backproj #(
   parameter int unsigned DEPTH_COLS = dcreg_pkg::DEPTH_COLS,
   parameter int unsigned DEPTH_ROWS = dcreg_pkg::DEPTH_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  dcreg_pkg::req_type   in_item,
   input  dcreg_pkg::cfg_type   cfg,
   output logic                 out_valid,
   output dcreg_pkg::point_type out_point
);

   localparam int unsigned NW = dcreg_pkg::BP_NW;
   localparam int unsigned DW = dcreg_pkg::BP_DW;

   // Stage 1: centered coordinates.
   logic               s1_valid_ff;
   logic signed [16:0] s1_dx_ff, s1_dy_ff;
   logic [15:0]        s1_d_ff;
   logic               s1_inr_ff;
   logic signed [16:0] s1_dx_in, s1_dy_in;
   logic               s1_inr_in;

   // Stage 2: products with depth.
   logic               s2_valid_ff;
   logic signed [33:0] s2_px_ff, s2_py_ff;
   logic [15:0]        s2_d_ff;
   logic               s2_inr_ff;

   // Stage 3: rounding dividends.
   logic               s3_valid_ff;
   logic [NW-1:0]      s3_nx_ff, s3_ny_ff;
   logic               s3_negx_ff, s3_negy_ff;
   logic [15:0]        s3_d_ff;
   logic               s3_inr_ff;
   logic [33:0]        magx, magy;

   logic               dx_valid, dy_valid;
   logic [NW-1:0]      qx, qy;
   logic [18:0]        tagx;
   logic [1:0]         tagy;

   logic                 out_valid_ff;
   dcreg_pkg::point_type out_point_ff;
   dcreg_pkg::point_type out_point_in;

   function automatic logic signed [31:0] sat32(input logic neg, input logic [NW-1:0] q);
      logic signed [31:0] r;
      if (neg) begin
         if (q > NW'(33'h0_8000_0000)) r = 32'sh8000_0000;
         else r = -$signed(q[31:0]);
      end else begin
         if (q > NW'(33'h0_7FFF_FFFF)) r = 32'sh7FFF_FFFF;
         else r = $signed(q[31:0]);
      end
      return r;
   endfunction

   assign s1_dx_in  = $signed({3'b0, in_item.depth_col, 4'b0}) - $signed({1'b0, cfg.dcx});
   assign s1_dy_in  = $signed({3'b0, in_item.depth_row, 4'b0}) - $signed({1'b0, cfg.dcy});
   assign s1_inr_in = ({1'b0, in_item.depth_col} < 11'(DEPTH_COLS))
                   && ({1'b0, in_item.depth_row} < 11'(DEPTH_ROWS));

   assign magx = s2_px_ff[33] ? 34'(-s2_px_ff) : s2_px_ff;
   assign magy = s2_py_ff[33] ? 34'(-s2_py_ff) : s2_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_d_ff    <= in_item.depth_mm;
         s1_inr_ff  <= s1_inr_in;
         s2_px_ff   <= s1_dx_ff * $signed({1'b0, s1_d_ff});
         s2_py_ff   <= s1_dy_ff * $signed({1'b0, s1_d_ff});
         s2_d_ff    <= s1_d_ff;
         s2_inr_ff  <= s1_inr_ff;
         // Dividend 2*|n|*16 + f, divisor 2*f gives round half away from zero.
         s3_nx_ff   <= NW'({magx[32:0], 5'b0}) + NW'(cfg.dfx);
         s3_ny_ff   <= NW'({magy[32:0], 5'b0}) + NW'(cfg.dfy);
         s3_negx_ff <= s2_px_ff[33];
         s3_negy_ff <= s2_py_ff[33];
         s3_d_ff    <= s2_d_ff;
         s3_inr_ff  <= s2_inr_ff;
      end
   end

   dcreg_div #(.NW(NW), .DW(DW), .TW(19)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s3_valid_ff),
      .num      (s3_nx_ff),
      .den      ({cfg.dfx, 1'b0}),
      .tag      ({s3_negx_ff, cfg.dfx == 16'd0, s3_inr_ff, s3_d_ff}),
      .out_valid(dx_valid),
      .quo      (qx),
      .out_tag  (tagx)
   );

   dcreg_div #(.NW(NW), .DW(DW), .TW(2)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s3_valid_ff),
      .num      (s3_ny_ff),
      .den      ({cfg.dfy, 1'b0}),
      .tag      ({s3_negy_ff, cfg.dfy == 16'd0}),
      .out_valid(dy_valid),
      .quo      (qy),
      .out_tag  (tagy)
   );

   always_comb begin
      out_point_in.x       = tagx[17] ? 32'sd0 : sat32(tagx[18], qx);
      out_point_in.y       = tagy[0]  ? 32'sd0 : sat32(tagy[1], qy);
      out_point_in.z       = {tagx[15:0], 4'b0};
      out_point_in.inrange = tagx[16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dx_valid & dy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_point_ff <= out_point_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_point = out_point_ff;

endmodule

// File: rtl/dcreg_xform.sv
// Rigid transform of a point from the depth camera frame into the color camera frame.
`timescale 1ns / 1ps

module dcreg_xform (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  dcreg_pkg::point_type in_point,
   input  dcreg_pkg::cfg_type   cfg,
   output logic                 out_valid,
   output dcreg_pkg::cam_type   out_point
);

   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [47:0]        prod_ff [3][3];
   logic signed [47:0]        prod_in [3][3];
   logic signed [49:0]        acc_ff  [3];
   logic signed [31:0]        res_in  [3];
   logic signed [31:0]        res_ff  [3];
   logic                      s1_inr_ff, s2_inr_ff, s3_inr_ff;
   logic signed [31:0]        coord   [3];

   assign coord[0] = in_point.x;
   assign coord[1] = in_point.y;
   assign coord[2] = $signed({12'b0, in_point.z});

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(cfg.rot[i][2-j]) * coord[j];
         end
      end
   end

   // Divide by 2^14 with rounding away from zero, add translation, saturate.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [49:0]        mag;
         logic [35:0]        q;
         logic signed [39:0] vq;
         logic signed [39:0] tsx;
         logic signed [39:0] val;
         mag = acc_ff[i][49] ? 50'(-acc_ff[i]) : acc_ff[i];
         q   = 36'((mag + 50'd8192) >> 14);
         vq  = $signed(40'(q));
         tsx = 40'($signed(cfg.trans[2-i]));
         val = (acc_ff[i][49] ? -vq : vq) + (tsx <<< 4);
         if (val > 40'sh00_7FFF_FFFF) res_in[i] = 32'sh7FFF_FFFF;
         else if (val < -40'sh00_8000_0000) res_in[i] = 32'sh8000_0000;
         else res_in[i] = val[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         s1_inr_ff <= in_point.inrange;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= 50'(prod_ff[i][0]) + 50'(prod_ff[i][1]) + 50'(prod_ff[i][2]);
         end
         s2_inr_ff <= s1_inr_ff;
         res_ff    <= res_in;
         s3_inr_ff <= s2_inr_ff;
      end
   end

   assign out_valid         = s3_valid_ff;
   assign out_point.xc      = res_ff[0];
   assign out_point.yc      = res_ff[1];
   assign out_point.zc      = res_ff[2];
   assign out_point.inrange = s3_inr_ff;

endmodule

// File: rtl/dcreg_proj.sv
// Projection through the color camera intrinsics, rounding, saturation and frame test.
`timescale 1ns / 1ps

module dcreg_proj (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  dcreg_pkg::cam_type in_point,
   input  dcreg_pkg::cfg_type cfg,
   output logic               out_valid,
   output dcreg_pkg::rsp_type out_item
);

   localparam int unsigned NW = dcreg_pkg::PJ_NW;
   localparam int unsigned DW = dcreg_pkg::PJ_DW;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [48:0] s1_ax_ff, s1_bx_ff, s1_ay_ff, s1_by_ff;
   logic signed [31:0] s1_zc_ff;
   logic               s1_inr_ff;
   logic signed [49:0] s2_nu_ff, s2_nv_ff;
   logic signed [31:0] s2_zc_ff;
   logic               s2_inr_ff;
   logic [NW-1:0]      s3_nu_ff, s3_nv_ff;
   logic [DW-1:0]      s3_den_ff;
   logic               s3_negu_ff, s3_negv_ff, s3_pos_ff, s3_inr_ff;
   logic [49:0]        magu, magv;
   logic [NW-1:0]      ud;

   logic               du_valid, dv_valid;
   logic [NW-1:0]      qu, qv;
   logic [0:0]         tagu;
   logic [2:0]         tagv;

   logic               out_valid_ff;
   dcreg_pkg::rsp_type out_item_ff;
   dcreg_pkg::rsp_type out_item_in;

   function automatic logic signed [15:0] sat16(input logic neg, input logic [NW-1:0] q);
      logic signed [15:0] r;
      if (neg) begin
         if (q > NW'(17'h0_8000)) r = 16'sh8000;
         else r = -$signed(q[15:0]);
      end else begin
         if (q > NW'(17'h0_7FFF)) r = 16'sh7FFF;
         else r = $signed(q[15:0]);
      end
      return r;
   endfunction

   assign magu = s2_nu_ff[49] ? 50'(-s2_nu_ff) : s2_nu_ff;
   assign magv = s2_nv_ff[49] ? 50'(-s2_nv_ff) : s2_nv_ff;
   assign ud   = NW'({s2_zc_ff[30:0], 4'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ax_ff   <= in_point.xc * $signed({1'b0, cfg.cfx});
         s1_bx_ff   <= $signed({1'b0, cfg.ccx}) * in_point.zc;
         s1_ay_ff   <= in_point.yc * $signed({1'b0, cfg.cfy});
         s1_by_ff   <= $signed({1'b0, cfg.ccy}) * in_point.zc;
         s1_zc_ff   <= in_point.zc;
         s1_inr_ff  <= in_point.inrange;
         s2_nu_ff   <= 50'(s1_ax_ff) + 50'(s1_bx_ff);
         s2_nv_ff   <= 50'(s1_ay_ff) + 50'(s1_by_ff);
         s2_zc_ff   <= s1_zc_ff;
         s2_inr_ff  <= s1_inr_ff;
         // Dividend 2*|n| + 16*zc over divisor 32*zc rounds half away from zero.
         s3_nu_ff   <= NW'({magu[48:0], 1'b0}) + ud;
         s3_nv_ff   <= NW'({magv[48:0], 1'b0}) + ud;
         s3_den_ff  <= {s2_zc_ff[30:0], 5'b0};
         s3_negu_ff <= s2_nu_ff[49];
         s3_negv_ff <= s2_nv_ff[49];
         s3_pos_ff  <= ~s2_zc_ff[31] && (s2_zc_ff != 32'sd0);
         s3_inr_ff  <= s2_inr_ff;
      end
   end

   dcreg_div #(.NW(NW), .DW(DW), .TW(1)) u_div_u (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s3_valid_ff),
      .num      (s3_nu_ff),
      .den      (s3_den_ff),
      .tag      (s3_negu_ff),
      .out_valid(du_valid),
      .quo      (qu),
      .out_tag  (tagu)
   );

   dcreg_div #(.NW(NW), .DW(DW), .TW(3)) u_div_v (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s3_valid_ff),
      .num      (s3_nv_ff),
      .den      (s3_den_ff),
      .tag      ({s3_negv_ff, s3_pos_ff, s3_inr_ff}),
      .out_valid(dv_valid),
      .quo      (qv),
      .out_tag  (tagv)
   );

   always_comb begin
      logic u_ok, v_ok;
      u_ok = (!tagu[0] || qu == '0) && (qu < NW'(cfg.fw));
      v_ok = (!tagv[2] || qv == '0) && (qv < NW'(cfg.fh));
      if (tagv[1]) begin
         out_item_in.color_col    = sat16(tagu[0], qu);
         out_item_in.color_row    = sat16(tagv[2], qv);
         out_item_in.inside_frame = u_ok && v_ok && tagv[0];
      end else begin
         out_item_in.color_col    = '0;
         out_item_in.color_row    = '0;
         out_item_in.inside_frame = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= du_valid & dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_item_ff <= out_item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// File: rtl/depth_to_color_pixel_registration_core.sv
// Top level of the depth-to-color pixel registration core.
`timescale 1ns / 1ps

// Maps each depth pixel (column, row, depth in millimetres) to the rounded pixel
// coordinate in the color image and flags whether that coordinate lies inside the
// color frame and the pixel inside the depth frame. The pixel is back-projected
// through the depth intrinsics (Q12.4), rotated (Q2.14) and translated (mm), and
// projected through the color intrinsics; all rounding is to nearest with ties
// away from zero, coordinates saturate to 16 bits signed, and a transformed depth
// of zero or less gives an all-zero result. The datapath is a single pipeline that
// takes one item per clock while not stalled; its depth is made up of the two
// bit-serial division pipelines, 39 stages for the back-projection and 50 stages
// for the projection, plus eleven stages of multiply, add and rounding around
// them. When the result side stalls with a result waiting, the whole pipeline
// holds and the request side sees stall; while the output register is empty or
// being drained, a new item is taken every cycle.
// Configuration is written over the csr port (always ready) and must only change
// while no item is in flight; 32-bit registers use the low half of csr_data.
module depth_to_color_pixel_registration_core #(
   parameter int unsigned DEPTH_COLS = dcreg_pkg::DEPTH_COLS,
   parameter int unsigned DEPTH_ROWS = dcreg_pkg::DEPTH_ROWS
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  dcreg_pkg::req_type req_item,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dcreg_pkg::rsp_type rsp_item,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   logic [31:0] depth_focal_ff, depth_center_ff, color_focal_ff, color_center_ff;
   logic [63:0] ext_row_x_ff, ext_row_y_ff, ext_row_z_ff;
   logic [31:0] frame_size_ff;

   dcreg_pkg::cfg_type   cfg;
   logic                 advance;
   logic                 bp_valid, xf_valid;
   dcreg_pkg::point_type bp_point;
   dcreg_pkg::cam_type   xf_point;

   // The configuration port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_focal_ff  <= dcreg_pkg::RST_DEPTH_FOCAL;
         depth_center_ff <= dcreg_pkg::RST_DEPTH_CENTER;
         color_focal_ff  <= dcreg_pkg::RST_COLOR_FOCAL;
         color_center_ff <= dcreg_pkg::RST_COLOR_CENTER;
         ext_row_x_ff    <= dcreg_pkg::RST_EXT_ROW_X;
         ext_row_y_ff    <= dcreg_pkg::RST_EXT_ROW_Y;
         ext_row_z_ff    <= dcreg_pkg::RST_EXT_ROW_Z;
         frame_size_ff   <= dcreg_pkg::RST_FRAME_SIZE;
      end else if (csr_valid) begin
         case (dcreg_pkg::csr_index_type'(csr_index))
            dcreg_pkg::REG_DEPTH_FOCAL:  depth_focal_ff  <= csr_data[31:0];
            dcreg_pkg::REG_DEPTH_CENTER: depth_center_ff <= csr_data[31:0];
            dcreg_pkg::REG_COLOR_FOCAL:  color_focal_ff  <= csr_data[31:0];
            dcreg_pkg::REG_COLOR_CENTER: color_center_ff <= csr_data[31:0];
            dcreg_pkg::REG_EXT_ROW_X:    ext_row_x_ff    <= csr_data;
            dcreg_pkg::REG_EXT_ROW_Y:    ext_row_y_ff    <= csr_data;
            dcreg_pkg::REG_EXT_ROW_Z:    ext_row_z_ff    <= csr_data;
            dcreg_pkg::REG_FRAME_SIZE:   frame_size_ff   <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // Split the packed registers into their fields once for all stages.
   always_comb begin
      cfg.dfx      = depth_focal_ff[31:16];
      cfg.dfy      = depth_focal_ff[15:0];
      cfg.dcx      = depth_center_ff[31:16];
      cfg.dcy      = depth_center_ff[15:0];
      cfg.cfx      = color_focal_ff[31:16];
      cfg.cfy      = color_focal_ff[15:0];
      cfg.ccx      = color_center_ff[31:16];
      cfg.ccy      = color_center_ff[15:0];
      cfg.rot[0]   = ext_row_x_ff[63:16];
      cfg.rot[1]   = ext_row_y_ff[63:16];
      cfg.rot[2]   = ext_row_z_ff[63:16];
      // trans[2] is the x translation so that rot and trans index alike from the top.
      cfg.trans[2] = ext_row_x_ff[15:0];
      cfg.trans[1] = ext_row_y_ff[15:0];
      cfg.trans[0] = ext_row_z_ff[15:0];
      cfg.fw       = frame_size_ff[31:16];
      cfg.fh       = frame_size_ff[15:0];
   end

   // Every stage moves together unless a finished result is held by the receiver.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   dcreg_backproj #(
      .DEPTH_COLS(DEPTH_COLS),
      .DEPTH_ROWS(DEPTH_ROWS)
   ) u_backproj (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_valid (req_valid),
      .in_item  (req_item),
      .cfg      (cfg),
      .out_valid(bp_valid),
      .out_point(bp_point)
   );

   dcreg_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_valid (bp_valid),
      .in_point (bp_point),
      .cfg      (cfg),
      .out_valid(xf_valid),
      .out_point(xf_point)
   );

   // The last stage of the projection is the output register.
   dcreg_proj u_proj (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_valid (xf_valid),
      .in_point (xf_point),
      .cfg      (cfg),
      .out_valid(rsp_valid),
      .out_item (rsp_item)
   );

endmodule
